/* hdl/assert_macros.svh */
// Assertion macros used by orbital_circularity_ratio.sv.
// OCR_ASSERT expects clk and rst_n, OCR_ASSERT_ALWAYS only clk, in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted
`define OCR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked property that also holds during reset
`define OCR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/ocr_pkg.sv */
// Package for the orbital circularity ratio block.
// Word types, register indexes and pipeline sideband; no dependencies.
package ocr_pkg;

    localparam int DATA_W    = 24;
    localparam int RESULT_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X     = 2'd0,
        REG_CENTER_Y     = 2'd1,
        REG_CENTER_Z     = 2'd2,
        REG_SPATIAL_MODE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic signed [DATA_W-1:0] vel_z;
        logic                     last_particle;
    } in_word_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] circularity_value;
        logic                       degenerate;
        logic                       last_out;
    } out_word_t;

    // Control that travels with each word down the pipeline
    typedef struct packed {
        logic valid;
        logic neg;
        logic degen;
        logic last;
    } side_t;

endpackage

/* hdl/ocr_front.sv */
// Front end: center offset, cross products, squared norms and the two
// wide products that feed the square roots. Uses ocr_pkg.
module ocr_front #(
    parameter int DATA_WIDTH = ocr_pkg::DATA_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid_i,
    input  logic                         last_i,
    input  logic signed [DATA_WIDTH-1:0] pos_x,
    input  logic signed [DATA_WIDTH-1:0] pos_y,
    input  logic signed [DATA_WIDTH-1:0] pos_z,
    input  logic signed [DATA_WIDTH-1:0] vel_x,
    input  logic signed [DATA_WIDTH-1:0] vel_y,
    input  logic signed [DATA_WIDTH-1:0] vel_z,
    input  logic signed [DATA_WIDTH-1:0] center_x,
    input  logic signed [DATA_WIDTH-1:0] center_y,
    input  logic signed [DATA_WIDTH-1:0] center_z,
    input  logic                         spatial_mode,
    output ocr_pkg::side_t               side_o,
    output logic [4*DATA_WIDTH+1:0]      num_op,
    output logic [4*DATA_WIDTH+1:0]      den_op
);

    localparam int DW  = DATA_WIDTH;
    localparam int RW  = DW + 1;       // r component
    localparam int PW  = 2 * DW + 1;   // r*v product
    localparam int LW  = 2 * DW + 2;   // signed L component
    localparam int LM  = 2 * DW + 1;   // |L component|
    localparam int H   = DW + 1;       // low split of |L component|
    localparam int RSW = 2 * DW + 1;   // r squared
    localparam int VSW = 2 * DW - 1;   // v squared
    localparam int SRW = 2 * DW + 2;   // |r|^2
    localparam int SVW = 2 * DW;       // |v|^2
    localparam int SW  = 4 * DW + 2;   // square root operand

    // ---------------- stage A: offset from center
    ocr_pkg::side_t a_side_reg, a_side_next;
    logic a_mode_reg;
    logic signed [RW-1:0] rx_reg, ry_reg, rz_reg, rx_next, ry_next, rz_next;
    logic signed [DW-1:0] vx_reg, vy_reg, vz_reg;

    always_comb
    begin
        rx_next = RW'(pos_x) - RW'(center_x);
        ry_next = RW'(pos_y) - RW'(center_y);
        rz_next = RW'(pos_z) - RW'(center_z);
        a_side_next.valid = valid_i;
        a_side_next.neg   = 1'b0;
        a_side_next.last  = last_i;
        // zero r or zero v gives a zero denominator
        a_side_next.degen = (rx_next == '0 && ry_next == '0 && rz_next == '0) ||
                            (vel_x == '0 && vel_y == '0 && vel_z == '0);
    end

    // ---------------- stage B: products
    ocr_pkg::side_t b_side_reg;
    logic b_mode_reg;
    logic signed [PW-1:0] pa_x_reg, pb_x_reg, pa_y_reg, pb_y_reg, pa_z_reg, pb_z_reg;
    logic [RSW-1:0] rsq_x_reg, rsq_y_reg, rsq_z_reg;
    logic [VSW-1:0] vsq_x_reg, vsq_y_reg, vsq_z_reg;
    logic signed [2*RW-1:0] rsq_x_full, rsq_y_full, rsq_z_full;
    logic signed [2*DW-1:0] vsq_x_full, vsq_y_full, vsq_z_full;
    logic signed [PW-1:0] pa_x_next, pb_x_next, pa_y_next, pb_y_next, pa_z_next, pb_z_next;

    always_comb
    begin
        pa_x_next  = ry_reg * vz_reg;
        pb_x_next  = rz_reg * vy_reg;
        pa_y_next  = rz_reg * vx_reg;
        pb_y_next  = rx_reg * vz_reg;
        pa_z_next  = rx_reg * vy_reg;
        pb_z_next  = ry_reg * vx_reg;
        rsq_x_full = rx_reg * rx_reg;
        rsq_y_full = ry_reg * ry_reg;
        rsq_z_full = rz_reg * rz_reg;
        vsq_x_full = vx_reg * vx_reg;
        vsq_y_full = vy_reg * vy_reg;
        vsq_z_full = vz_reg * vz_reg;
    end

    // ---------------- stage C: L = r x v, squared norms
    ocr_pkg::side_t c_side_reg, c_side_next;
    logic c_mode_reg;
    logic [LM-1:0] lm_x_reg, lm_y_reg, lm_z_reg, lm_x_next, lm_y_next, lm_z_next;
    logic [SRW-1:0] sr_reg, sr_next;
    logic [SVW-1:0] sv_reg, sv_next;
    logic signed [LW-1:0] l_x, l_y, l_z;
    logic neg_z_next;

    always_comb
    begin
        l_x = LW'(pa_x_reg) - LW'(pb_x_reg);
        l_y = LW'(pa_y_reg) - LW'(pb_y_reg);
        l_z = LW'(pa_z_reg) - LW'(pb_z_reg);
        lm_x_next = l_x[LW-1] ? LM'(-l_x) : LM'(l_x);
        lm_y_next = l_y[LW-1] ? LM'(-l_y) : LM'(l_y);
        lm_z_next = l_z[LW-1] ? LM'(-l_z) : LM'(l_z);
        neg_z_next = l_z[LW-1];
        sr_next = SRW'(rsq_x_reg) + SRW'(rsq_y_reg) + SRW'(rsq_z_reg);
        sv_next = SVW'(vsq_x_reg) + SVW'(vsq_y_reg) + SVW'(vsq_z_reg);
        // sign of Lz only matters in planar mode
        c_side_next     = b_side_reg;
        c_side_next.neg = neg_z_next & ~b_mode_reg;
    end

    // ---------------- stage D: partial products of the wide squares
    ocr_pkg::side_t d_side_reg;
    logic d_mode_reg;
    logic [2*DW-1:0] hh_x_reg, hh_y_reg, hh_z_reg;
    logic [2*DW:0]   hl_x_reg, hl_y_reg, hl_z_reg;
    logic [2*H-1:0]  ll_x_reg, ll_y_reg, ll_z_reg;
    logic [2*DW:0]   pp11_reg, pp10_reg, pp01_reg, pp00_reg;
    logic [2*DW-1:0] hh_x_next, hh_y_next, hh_z_next;
    logic [2*DW:0]   hl_x_next, hl_y_next, hl_z_next;
    logic [2*H-1:0]  ll_x_next, ll_y_next, ll_z_next;
    logic [2*DW:0]   pp11_next, pp10_next, pp01_next, pp00_next;
    logic [DW:0]     sr_lo, sr_hi;
    logic [DW-1:0]   sv_lo, sv_hi;

    always_comb
    begin
        hh_x_next = lm_x_reg[LM-1:H] * lm_x_reg[LM-1:H];
        hh_y_next = lm_y_reg[LM-1:H] * lm_y_reg[LM-1:H];
        hh_z_next = lm_z_reg[LM-1:H] * lm_z_reg[LM-1:H];
        hl_x_next = lm_x_reg[LM-1:H] * lm_x_reg[H-1:0];
        hl_y_next = lm_y_reg[LM-1:H] * lm_y_reg[H-1:0];
        hl_z_next = lm_z_reg[LM-1:H] * lm_z_reg[H-1:0];
        ll_x_next = lm_x_reg[H-1:0] * lm_x_reg[H-1:0];
        ll_y_next = lm_y_reg[H-1:0] * lm_y_reg[H-1:0];
        ll_z_next = lm_z_reg[H-1:0] * lm_z_reg[H-1:0];
        sr_lo = sr_reg[DW:0];
        sr_hi = sr_reg[SRW-1:DW+1];
        sv_lo = sv_reg[DW-1:0];
        sv_hi = sv_reg[SVW-1:DW];
        pp11_next = sr_hi * sv_hi;
        pp10_next = sr_hi * sv_lo;
        pp01_next = sr_lo * sv_hi;
        pp00_next = sr_lo * sv_lo;
    end

    // ---------------- stage E: recombine into root operands
    ocr_pkg::side_t e_side_reg;
    logic [SW-1:0] num_reg, den_reg, num_next, den_next;
    logic [SW-1:0] sq_x, sq_y, sq_z;

    always_comb
    begin
        sq_x = (SW'(hh_x_reg) << (2 * H)) + (SW'(hl_x_reg) << (H + 1)) + SW'(ll_x_reg);
        sq_y = (SW'(hh_y_reg) << (2 * H)) + (SW'(hl_y_reg) << (H + 1)) + SW'(ll_y_reg);
        sq_z = (SW'(hh_z_reg) << (2 * H)) + (SW'(hl_z_reg) << (H + 1)) + SW'(ll_z_reg);
        // planar mode takes the root of Lz^2, which is exactly |Lz|
        num_next = d_mode_reg ? (sq_x + sq_y + sq_z) : sq_z;
        den_next = (SW'(pp11_reg) << (2 * DW + 1)) + (SW'(pp10_reg) << (DW + 1)) +
                   (SW'(pp01_reg) << DW) + SW'(pp00_reg);
    end

    // sideband registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_side_reg <= '0;
            b_side_reg <= '0;
            c_side_reg <= '0;
            d_side_reg <= '0;
            e_side_reg <= '0;
        end
        else if (en)
        begin
            a_side_reg <= a_side_next;
            b_side_reg <= a_side_reg;
            c_side_reg <= c_side_next;
            d_side_reg <= c_side_reg;
            e_side_reg <= d_side_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mode_reg <= spatial_mode;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
            vx_reg <= vel_x;
            vy_reg <= vel_y;
            vz_reg <= vel_z;

            b_mode_reg <= a_mode_reg;
            pa_x_reg <= pa_x_next;
            pb_x_reg <= pb_x_next;
            pa_y_reg <= pa_y_next;
            pb_y_reg <= pb_y_next;
            pa_z_reg <= pa_z_next;
            pb_z_reg <= pb_z_next;
            rsq_x_reg <= rsq_x_full[RSW-1:0];
            rsq_y_reg <= rsq_y_full[RSW-1:0];
            rsq_z_reg <= rsq_z_full[RSW-1:0];
            vsq_x_reg <= vsq_x_full[VSW-1:0];
            vsq_y_reg <= vsq_y_full[VSW-1:0];
            vsq_z_reg <= vsq_z_full[VSW-1:0];

            c_mode_reg <= b_mode_reg;
            lm_x_reg <= lm_x_next;
            lm_y_reg <= lm_y_next;
            lm_z_reg <= lm_z_next;
            sr_reg <= sr_next;
            sv_reg <= sv_next;

            d_mode_reg <= c_mode_reg;
            hh_x_reg <= hh_x_next;
            hh_y_reg <= hh_y_next;
            hh_z_reg <= hh_z_next;
            hl_x_reg <= hl_x_next;
            hl_y_reg <= hl_y_next;
            hl_z_reg <= hl_z_next;
            ll_x_reg <= ll_x_next;
            ll_y_reg <= ll_y_next;
            ll_z_reg <= ll_z_next;
            pp11_reg <= pp11_next;
            pp10_reg <= pp10_next;
            pp01_reg <= pp01_next;
            pp00_reg <= pp00_next;

            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign side_o = e_side_reg;
    assign num_op = num_reg;
    assign den_op = den_reg;

endmodule

/* hdl/ocr_sqrt_cell.sv */
// One cell of the square root chain: one root bit for the denominator
// and one for the numerator per cell. Uses ocr_pkg.
module ocr_sqrt_cell #(
    parameter int SW  = 4 * ocr_pkg::DATA_W + 2,
    parameter int RTW = 2 * ocr_pkg::DATA_W + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  ocr_pkg::side_t    side_i,
    input  logic [SW-1:0]     xd_i,
    input  logic [RTW+1:0]    rd_i,
    input  logic [RTW-1:0]    qd_i,
    input  logic [SW-1:0]     xn_i,
    input  logic [RTW+1:0]    rn_i,
    input  logic [RTW-1:0]    qn_i,
    output ocr_pkg::side_t    side_o,
    output logic [SW-1:0]     xd_o,
    output logic [RTW+1:0]    rd_o,
    output logic [RTW-1:0]    qd_o,
    output logic [SW-1:0]     xn_o,
    output logic [RTW+1:0]    rn_o,
    output logic [RTW-1:0]    qn_o
);

    localparam int RMW = RTW + 2;

    ocr_pkg::side_t side_reg;
    logic [SW-1:0]  xd_reg, xn_reg, xd_next, xn_next;
    logic [RMW-1:0] rd_reg, rn_reg, rd_next, rn_next;
    logic [RTW-1:0] qd_reg, qn_reg, qd_next, qn_next;
    logic [RMW:0]   d_sh, d_trial, n_sh, n_trial;
    logic           d_ge, n_ge;

    // restoring root step: bring down two operand bits, try 4q+1
    always_comb
    begin
        d_sh    = {rd_i[RTW:0], xd_i[SW-1:SW-2]};
        d_trial = {1'b0, qd_i, 2'b01};
        d_ge    = d_sh >= d_trial;
        rd_next = d_ge ? RMW'(d_sh - d_trial) : RMW'(d_sh);
        qd_next = {qd_i[RTW-2:0], d_ge};
        xd_next = {xd_i[SW-3:0], 2'b00};

        n_sh    = {rn_i[RTW:0], xn_i[SW-1:SW-2]};
        n_trial = {1'b0, qn_i, 2'b01};
        n_ge    = n_sh >= n_trial;
        rn_next = n_ge ? RMW'(n_sh - n_trial) : RMW'(n_sh);
        qn_next = {qn_i[RTW-2:0], n_ge};
        xn_next = {xn_i[SW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xd_reg <= xd_next;
            rd_reg <= rd_next;
            qd_reg <= qd_next;
            xn_reg <= xn_next;
            rn_reg <= rn_next;
            qn_reg <= qn_next;
        end
    end

    assign side_o = side_reg;
    assign xd_o   = xd_reg;
    assign rd_o   = rd_reg;
    assign qd_o   = qd_reg;
    assign xn_o   = xn_reg;
    assign rn_o   = rn_reg;
    assign qn_o   = qn_reg;

endmodule

/* hdl/ocr_div_cell.sv */
// One cell of the divider chain: one quotient bit per cell.
// Uses ocr_pkg for the sideband type.
module ocr_div_cell #(
    parameter int RTW = 2 * ocr_pkg::DATA_W + 1,
    parameter int RES = ocr_pkg::RESULT_W
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  ocr_pkg::side_t  side_i,
    input  logic [RTW:0]    r_i,
    input  logic [RTW-1:0]  d_i,
    input  logic [RES-1:0]  q_i,
    output ocr_pkg::side_t  side_o,
    output logic [RTW:0]    r_o,
    output logic [RTW-1:0]  d_o,
    output logic [RES-1:0]  q_o
);

    ocr_pkg::side_t side_reg;
    logic [RTW:0]   r_reg, r_next, r_sub;
    logic [RTW-1:0] d_reg;
    logic [RES-1:0] q_reg, q_next;
    logic           ge;

    // restoring step; the partial remainder stays below the divisor
    always_comb
    begin
        ge     = r_i >= {1'b0, d_i};
        r_sub  = ge ? (r_i - {1'b0, d_i}) : r_i;
        r_next = {r_sub[RTW-1:0], 1'b0};
        q_next = {q_i[RES-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            d_reg <= d_i;
            q_reg <= q_next;
        end
    end

    assign side_o = side_reg;
    assign r_o    = r_reg;
    assign d_o    = d_reg;
    assign q_o    = q_reg;

endmodule

/* hdl/orbital_circularity_ratio.sv */
// Pipeline: five front stages, one root cell per root bit, one divider cell per
// result bit and the output register. Throughput: one word per cycle; the whole
// pipeline advances when the output register is empty or being taken. Reset
// (rst_n, async, active low) clears the configuration registers and all valid bits.
`include "assert_macros.svh"

module orbital_circularity_ratio #(
    parameter int DATA_WIDTH   = ocr_pkg::DATA_W,
    parameter int RESULT_WIDTH = ocr_pkg::RESULT_W
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ocr_pkg::in_word_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ocr_pkg::out_word_t              out_data,
    input  logic                            cfg_we,
    input  logic [ocr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ocr_pkg::DATA_W-1:0]      cfg_wdata
);

    localparam int DW  = DATA_WIDTH;
    localparam int RES = RESULT_WIDTH;
    localparam int SW  = 4 * DW + 2;
    localparam int RTW = 2 * DW + 1;

    // ---------------- configuration registers
    logic signed [DW-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic                 mode_reg;
    logic signed [ocr_pkg::DATA_W-1:0] cfg_sdata;

    assign cfg_sdata = cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            mode_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (ocr_pkg::cfg_reg_t'(cfg_index))
                ocr_pkg::REG_CENTER_X:     center_x_reg <= DW'(cfg_sdata);
                ocr_pkg::REG_CENTER_Y:     center_y_reg <= DW'(cfg_sdata);
                ocr_pkg::REG_CENTER_Z:     center_z_reg <= DW'(cfg_sdata);
                ocr_pkg::REG_SPATIAL_MODE: mode_reg     <= cfg_wdata[0];
                default:                   mode_reg     <= mode_reg;
            endcase
        end
    end

    // ---------------- pipeline advance
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- front end
    ocr_pkg::side_t  f_side;
    logic [SW-1:0]   f_num, f_den;

    ocr_front #(
        .DATA_WIDTH (DW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .valid_i      (in_valid),
        .last_i       (in_data.last_particle),
        .pos_x        (DW'(in_data.pos_x)),
        .pos_y        (DW'(in_data.pos_y)),
        .pos_z        (DW'(in_data.pos_z)),
        .vel_x        (DW'(in_data.vel_x)),
        .vel_y        (DW'(in_data.vel_y)),
        .vel_z        (DW'(in_data.vel_z)),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .center_z     (center_z_reg),
        .spatial_mode (mode_reg),
        .side_o       (f_side),
        .num_op       (f_num),
        .den_op       (f_den)
    );

    // ---------------- square root chain
    ocr_pkg::side_t s_side [0:RTW];
    logic [SW-1:0]  s_xd [0:RTW];
    logic [SW-1:0]  s_xn [0:RTW];
    logic [RTW+1:0] s_rd [0:RTW];
    logic [RTW+1:0] s_rn [0:RTW];
    logic [RTW-1:0] s_qd [0:RTW];
    logic [RTW-1:0] s_qn [0:RTW];

    assign s_side[0] = f_side;
    assign s_xd[0]   = f_den;
    assign s_xn[0]   = f_num;
    assign s_rd[0]   = '0;
    assign s_rn[0]   = '0;
    assign s_qd[0]   = '0;
    assign s_qn[0]   = '0;

    for (genvar i = 0; i < RTW; i++)
    begin : g_sqrt
        ocr_sqrt_cell #(
            .SW  (SW),
            .RTW (RTW)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .side_i (s_side[i]),
            .xd_i   (s_xd[i]),
            .rd_i   (s_rd[i]),
            .qd_i   (s_qd[i]),
            .xn_i   (s_xn[i]),
            .rn_i   (s_rn[i]),
            .qn_i   (s_qn[i]),
            .side_o (s_side[i+1]),
            .xd_o   (s_xd[i+1]),
            .rd_o   (s_rd[i+1]),
            .qd_o   (s_qd[i+1]),
            .xn_o   (s_xn[i+1]),
            .rn_o   (s_rn[i+1]),
            .qn_o   (s_qn[i+1])
        );
    end

    // ---------------- divider chain
    ocr_pkg::side_t d_side [0:RES];
    logic [RTW:0]   d_r [0:RES];
    logic [RTW-1:0] d_d [0:RES];
    logic [RES-1:0] d_q [0:RES];

    // the numerator never exceeds the denominator
    assign d_side[0] = s_side[RTW];
    assign d_r[0]    = {1'b0, s_qn[RTW]};
    assign d_d[0]    = s_qd[RTW];
    assign d_q[0]    = '0;

    for (genvar j = 0; j < RES; j++)
    begin : g_div
        ocr_div_cell #(
            .RTW (RTW),
            .RES (RES)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .side_i (d_side[j]),
            .r_i    (d_r[j]),
            .d_i    (d_d[j]),
            .q_i    (d_q[j]),
            .side_o (d_side[j+1]),
            .r_o    (d_r[j+1]),
            .d_o    (d_d[j+1]),
            .q_o    (d_q[j+1])
        );
    end

    // ---------------- sign, saturation and output register
    localparam logic [RES-1:0] POS_MAX = {1'b0, {(RES-1){1'b1}}};

    ocr_pkg::side_t    fin_side;
    logic [RES-1:0]    fin_q;
    logic [RES-1:0]    val_next;
    logic signed [RES-1:0] val_reg;
    logic              degen_reg, last_reg;

    assign fin_side = d_side[RES];
    assign fin_q    = d_q[RES];

    always_comb
    begin
        if (fin_side.degen)
        begin
            val_next = '0;
        end
        else if (fin_side.neg)
        begin
            val_next = RES'(-fin_q);
        end
        else
        begin
            val_next = (fin_q > POS_MAX) ? POS_MAX : fin_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg   <= val_next;
            degen_reg <= fin_side.degen;
            last_reg  <= fin_side.last;
        end
    end

    assign out_valid                  = out_valid_reg;
    assign out_data.circularity_value = ocr_pkg::RESULT_W'(val_reg);
    assign out_data.degenerate        = degen_reg;
    assign out_data.last_out          = last_reg;

    // ---------------- checks
    `OCR_ASSERT(a_degen_zero, out_valid && out_data.degenerate |-> out_data.circularity_value == 0, "degenerate word with nonzero value")
    `OCR_ASSERT(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
    `OCR_ASSERT(a_ready_path, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")
    `OCR_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "result valid during reset")

endmodule

/* tb/tb.sv */
// Testbench for orbital_circularity_ratio: directed and random particle words,
// checked against an in-bench circularity predictor. Depends on ocr_pkg.
`timescale 1ns / 1ps

typedef logic [127:0] u128_t;

class circularity_scoreboard;
    logic signed [ocr_pkg::DATA_W-1:0] cx, cy, cz;
    bit                                spatial;
    ocr_pkg::out_word_t                expected_q[$];
    int                                errors;

    function new();
        cx = '0;
        cy = '0;
        cz = '0;
        spatial = 1'b0;
        errors = 0;
    endfunction

    // floor square root of a value below 2^128
    function u128_t floor_sqrt(u128_t a);
        u128_t root, trial;
        root = '0;
        for (int k = 63; k >= 0; k--)
        begin
            trial = root | (u128_t'(1) << k);
            if (trial * trial <= a)
                root = trial;
        end
        return root;
    endfunction

    // work out the expected result word for one accepted particle
    function void note(ocr_pkg::in_word_t w);
        longint rx, ry, rz, vx, vy, vz, lx, ly, lz, rsq, vsq;
        u128_t den, num, quo, lim, ax, ay, az;
        bit neg;
        ocr_pkg::out_word_t res;
        rx = longint'(w.pos_x) - longint'(cx);
        ry = longint'(w.pos_y) - longint'(cy);
        rz = longint'(w.pos_z) - longint'(cz);
        vx = longint'(w.vel_x);
        vy = longint'(w.vel_y);
        vz = longint'(w.vel_z);
        lx = ry * vz - rz * vy;
        ly = rz * vx - rx * vz;
        lz = rx * vy - ry * vx;
        rsq = rx * rx + ry * ry + rz * rz;
        vsq = vx * vx + vy * vy + vz * vz;
        den = floor_sqrt(u128_t'(rsq) * u128_t'(vsq));
        res = '0;
        res.last_out = w.last_particle;
        if (den == 0)
            res.degenerate = 1'b1;
        else
        begin
            if (spatial)
            begin
                neg = 1'b0;
                // squares of L components need more than 64 bits
                ax = (lx < 0) ? u128_t'(-lx) : u128_t'(lx);
                ay = (ly < 0) ? u128_t'(-ly) : u128_t'(ly);
                az = (lz < 0) ? u128_t'(-lz) : u128_t'(lz);
                num = floor_sqrt(ax * ax + ay * ay + az * az);
            end
            else
            begin
                neg = (lz < 0);
                num = neg ? u128_t'(-lz) : u128_t'(lz);
            end
            quo = (num << (ocr_pkg::RESULT_W - 1)) / den;
            lim = neg ? (u128_t'(1) << (ocr_pkg::RESULT_W - 1))
                      : (u128_t'(1) << (ocr_pkg::RESULT_W - 1)) - 1;
            if (quo > lim)
                quo = lim;
            res.circularity_value = neg ? -quo[ocr_pkg::RESULT_W-1:0]
                                        : quo[ocr_pkg::RESULT_W-1:0];
        end
        expected_q.push_back(res);
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check(ocr_pkg::out_word_t got);
        ocr_pkg::out_word_t exp_w;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result word %h", got);
            errors++;
            return;
        end
        exp_w = expected_q.pop_front();
        if (got.circularity_value !== exp_w.circularity_value)
        begin
            $error("circularity_value: expected %0d, got %0d",
                   exp_w.circularity_value, got.circularity_value);
            errors++;
        end
        if (got.degenerate !== exp_w.degenerate)
        begin
            $error("degenerate: expected %0b, got %0b", exp_w.degenerate, got.degenerate);
            errors++;
        end
        if (got.last_out !== exp_w.last_out)
        begin
            $error("last_out: expected %0b, got %0b", exp_w.last_out, got.last_out);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int DW        = ocr_pkg::DATA_W;
    localparam int LATENCY   = 5 + (2 * ocr_pkg::DATA_W + 1) + ocr_pkg::RESULT_W + 1;
    localparam int MAX_CYCLE = 2000000;
    localparam int SMAX      = (1 << (ocr_pkg::DATA_W - 1)) - 1;
    localparam int SMIN      = -(1 << (ocr_pkg::DATA_W - 1));

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    ocr_pkg::in_word_t             in_data;
    logic                          out_valid;
    logic                          out_ready;
    ocr_pkg::out_word_t            out_data;
    logic                          cfg_we;
    logic [ocr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ocr_pkg::DATA_W-1:0]    cfg_wdata;

    circularity_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    int recv_hold;
    int cycle_count;

    orbital_circularity_ratio uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: check accepted words, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check(out_data);
        if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(ocr_pkg::cfg_reg_t idx, logic [ocr_pkg::DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            ocr_pkg::REG_CENTER_X:     sb.cx = val;
            ocr_pkg::REG_CENTER_Y:     sb.cy = val;
            ocr_pkg::REG_CENTER_Z:     sb.cz = val;
            ocr_pkg::REG_SPATIAL_MODE: sb.spatial = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(int x, int y, int z, bit mode);
        write_reg(ocr_pkg::REG_CENTER_X, DW'(x));
        write_reg(ocr_pkg::REG_CENTER_Y, DW'(y));
        write_reg(ocr_pkg::REG_CENTER_Z, DW'(z));
        write_reg(ocr_pkg::REG_SPATIAL_MODE, DW'(mode));
    endtask

    // offer one word, holding it until the handshake
    task automatic send(ocr_pkg::in_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        // ready is sampled as it stood just before the edge
        @(posedge clk iff in_ready);
        sb.note(w);
    endtask

    // wait for every expected word, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic ocr_pkg::in_word_t mk(int px, int py, int pz, int vx, int vy, int vz,
                                             bit last);
        ocr_pkg::in_word_t w;
        w.pos_x = DW'(px);
        w.pos_y = DW'(py);
        w.pos_z = DW'(pz);
        w.vel_x = DW'(vx);
        w.vel_y = DW'(vy);
        w.vel_z = DW'(vz);
        w.last_particle = last;
        return w;
    endfunction

    function automatic int small_val();
        return int'($urandom_range(8)) - 4;
    endfunction

    // random particle: full range, small offsets, or a zero vector
    function automatic ocr_pkg::in_word_t rand_word();
        ocr_pkg::in_word_t w;
        int kind;
        kind = $urandom_range(9);
        w = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               1'($urandom_range(1)));
        if (kind >= 5 && kind <= 7)
        begin
            w.pos_x = DW'(sb.cx + small_val());
            w.pos_y = DW'(sb.cy + small_val());
            w.pos_z = DW'(sb.cz + small_val());
            w.vel_x = DW'(small_val());
            w.vel_y = DW'(small_val());
            w.vel_z = DW'(small_val());
        end
        else if (kind == 8)
        begin
            w.pos_x = sb.cx;
            w.pos_y = sb.cy;
            w.pos_z = sb.cz;
        end
        else if (kind == 9)
            w.vel_x = '0;
        if (kind == 9)
        begin
            w.vel_y = '0;
            w.vel_z = '0;
        end
        return w;
    endfunction

    task automatic random_phase(int count);
        for (int m = 0; m < 4; m++)
        begin
            send_idle_pct  = (m == 1 || m == 3) ? 72 : 0;
            recv_stall_pct = (m == 2 || m == 3) ? 72 : 0;
            if (m == 3)
            begin
                send_idle_pct  = 7;
                recv_stall_pct = 7;
            end
            for (int i = 0; i < count; i++)
                send(rand_word());
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, planar mode at reset center
        send(mk(0, 0, 0, 5, 6, 7, 1'b0));               // zero radius
        send(mk(3, 4, 5, 0, 0, 0, 1'b1));               // zero velocity
        send(mk(1, 0, 0, 0, 1, 0, 1'b0));               // saturates high
        send(mk(1, 0, 0, 0, -1, 0, 1'b1));              // most negative result
        send(mk(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, 1'b0));
        send(mk(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 1'b1));
        send(mk(SMAX, 0, 0, 0, SMIN, 0, 1'b0));
        send(mk(SMIN, 0, 0, 0, SMIN, 0, 1'b0));
        send(mk(SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, 1'b1));
        send(mk(-1, -1, -1, -1, -1, -1, 1'b0));
        send(mk(3, 4, 0, -4, 3, 0, 1'b0));
        send(mk(1, 1, 0, 1, 0, 0, 1'b1));
        drain();
        set_config(0, 0, 0, 1'b1);
        send(mk(1, 0, 0, 0, 1, 0, 1'b0));
        send(mk(0, 0, 1, 1, 0, 0, 1'b1));
        send(mk(1, 1, 1, 1, 1, 1, 1'b0));
        send(mk(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, 1'b1));
        send(mk(5, -3, 2, 0, 0, 0, 1'b0));
        send(mk(SMIN, SMIN, SMIN, SMAX, SMAX, SMIN, 1'b0));
        drain();

        // long receiver hold while the sender keeps offering
        recv_hold = 400;
        for (int i = 0; i < 150; i++)
            send(rand_word());
        drain();

        set_config(0, 0, 0, 1'b0);
        random_phase(60);
        set_config(SMAX, SMIN, SMAX, 1'b1);
        random_phase(60);
        set_config(SMIN, SMAX, SMIN, 1'b0);
        random_phase(60);
        set_config($urandom, $urandom, $urandom, 1'b1);
        random_phase(60);
        set_config($urandom, $urandom, $urandom, 1'b0);
        random_phase(60);

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

/* files.f */
+incdir+hdl
hdl/ocr_pkg.sv
hdl/ocr_front.sv
hdl/ocr_sqrt_cell.sv
hdl/ocr_div_cell.sv
hdl/orbital_circularity_ratio.sv
tb/tb.sv
